// ===== hdl/h264aus_pkg.sv =====
package h264aus_pkg;

   // Width of the frame byte counter; lengths saturate at 2**LENGTH_BITS - 1.
   localparam int LENGTH_BITS = 24;
   // Width of the reported frame length.
   localparam int FRAME_LENGTH_BITS = 24;
   localparam int SCL_BITS = 3;

   localparam logic [LENGTH_BITS-1:0] LENGTH_LIMIT = {LENGTH_BITS{1'b1}};

   localparam logic [SCL_BITS-1:0] SCL_SHORT = 3'd3;
   localparam logic [SCL_BITS-1:0] SCL_LONG  = 3'd4;

   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [FRAME_LENGTH_BITS-1:0] frame_length;
      logic                         length_overflow;
      logic                         closes_stream;
   } result_type;

   // Results written into the queue for one accepted byte.
   typedef struct packed {
      logic       push_first;
      logic       push_second;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== hdl/h264aus_front.sv =====
module h264aus_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [h264aus_pkg::SCL_BITS-1:0] csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_end_of_stream,
   input  logic                             queue_has_room,
   output h264aus_pkg::push_type            push
);
   import h264aus_pkg::*;

   logic [SCL_BITS-1:0]    scl_ff, scl_in;
   logic [31:0]            hist_ff, hist_in;
   logic [2:0]             hist_cnt_ff, hist_cnt_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   skip_ff, skip_in;
   logic                   sat_ff, sat_in;

   logic                   accept;
   logic                   held;
   logic [4:0]             nal_type;
   logic                   frame_end;
   logic [LENGTH_BITS-1:0] scl_ext;
   logic [LENGTH_BITS-1:0] end_length;
   result_type             end_result;
   result_type             close_result;

   assign req_ready = queue_has_room;
   assign accept    = req_valid && req_ready;
   assign nal_type  = req_data_byte[4:0];
   assign scl_ext   = {{(LENGTH_BITS-SCL_BITS){1'b0}}, scl_ff};

   always_comb begin
      held = 1'b0;
      if (scl_ff == SCL_LONG) begin
         held = (hist_cnt_ff >= 3'd4) && (hist_ff == 32'h0000_0001);
      end else if (scl_ff == SCL_SHORT) begin
         held = (hist_cnt_ff >= 3'd3) && (hist_ff[23:0] == 24'h00_0001);
      end
   end

   assign frame_end = held && !(nal_type inside {NAL_TYPE_PPS, NAL_TYPE_SPS}) && !skip_ff;

   always_comb begin
      if (sat_ff) begin
         end_length = LENGTH_LIMIT;
      end else if (count_ff >= scl_ext) begin
         end_length = count_ff - scl_ext;
      end else begin
         end_length = '0;
      end
   end

   always_comb begin
      scl_in      = csr_wr_en ? csr_wr_data : scl_ff;
      hist_in     = hist_ff;
      hist_cnt_in = hist_cnt_ff;
      count_in    = count_ff;
      skip_in     = skip_ff;
      sat_in      = sat_ff;
      if (accept) begin
         if (held && (nal_type == NAL_TYPE_PPS)) begin
            skip_in = 1'b1;
         end else if (held && (nal_type != NAL_TYPE_SPS) && skip_ff) begin
            skip_in = 1'b0;
         end
         if (frame_end) begin
            count_in = scl_ext + LENGTH_BITS'(1);
            sat_in   = 1'b0;
         end else if (count_ff == LENGTH_LIMIT) begin
            sat_in = 1'b1;
         end else begin
            count_in = count_ff + LENGTH_BITS'(1);
         end
         hist_in = {hist_ff[23:0], req_data_byte};
         if (hist_cnt_ff < 3'd4) begin
            hist_cnt_in = hist_cnt_ff + 3'd1;
         end
      end
   end

   always_comb begin
      end_result.frame_length      = FRAME_LENGTH_BITS'(end_length);
      end_result.length_overflow   = sat_ff;
      end_result.closes_stream     = 1'b0;
      close_result.frame_length    = FRAME_LENGTH_BITS'(sat_in ? LENGTH_LIMIT : count_in);
      close_result.length_overflow = sat_in;
      close_result.closes_stream   = 1'b1;

      push.push_first  = accept && (frame_end || req_end_of_stream);
      push.push_second = accept && frame_end && req_end_of_stream;
      push.first       = frame_end ? end_result : close_result;
      push.second      = close_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff      <= SCL_LONG;
         hist_ff     <= '0;
         hist_cnt_ff <= '0;
         count_ff    <= '0;
         skip_ff     <= 1'b1;
         sat_ff      <= 1'b0;
      end else begin
         scl_ff <= scl_in;
         if (accept && req_end_of_stream) begin
            // The stream is over: everything but the register starts afresh.
            hist_ff     <= '0;
            hist_cnt_ff <= '0;
            count_ff    <= '0;
            skip_ff     <= 1'b1;
            sat_ff      <= 1'b0;
         end else begin
            hist_ff     <= hist_in;
            hist_cnt_ff <= hist_cnt_in;
            count_ff    <= count_in;
            skip_ff     <= skip_in;
            sat_ff      <= sat_in;
         end
      end
   end

endmodule

// ===== hdl/h264aus_queue.sv =====
module h264aus_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  h264aus_pkg::push_type   push,
   output logic                    has_room,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output h264aus_pkg::result_type head
);
   import h264aus_pkg::*;

   result_type                mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      pop;
   logic [1:0]                n_push;

   // Room for the worst case of two results from one byte.
   assign has_room  = count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign head      = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = {1'b0, push.push_first} + {1'b0, push.push_second};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + QUEUE_CNT_BITS'(n_push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.push_second) begin
         mem[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/h264_access_unit_splitter_unit.sv =====
// Annex B access unit splitter: measures the frames of an H.264 byte stream.
//
// Input channel (req_*): one stream byte per transaction, with req_end_of_stream
// set on the last byte. Output channel (rsp_*): one transaction per frame that
// ends, carrying its length in bytes, an overflow flag when the length saturated,
// and a closing flag on the remainder frame reported at the end of the stream.
// The user must write the start code length (3 or 4) on csr_* while the block is idle.
//
// A byte is accepted in any cycle in which the result queue has room for two
// results, so the block takes one byte per cycle. A result enters the queue at
// the edge that accepts its byte and, if the queue was empty, is offered on
// rsp_* from the next cycle. The four-entry queue drains one result per cycle.
//
// When the receiver stalls, results collect in the queue and req_ready drops
// once fewer than two entries are free; no result is lost. Synchronous reset
// empties the queue, clears the byte history and counters, sets the skip flag
// and restores a start code length of four; the block does not enforce the idle rule.
module h264_access_unit_splitter_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [h264aus_pkg::SCL_BITS-1:0]          csr_wr_data,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [7:0]                                req_data_byte,
   input  logic                                      req_end_of_stream,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [h264aus_pkg::FRAME_LENGTH_BITS-1:0] rsp_frame_length,
   output logic                                      rsp_length_overflow,
   output logic                                      rsp_closes_stream
);
   import h264aus_pkg::*;

   push_type   push;
   logic       queue_has_room;
   result_type head;

   // The front end tracks the start codes and frame counts and decides, for
   // each byte, which results (if any) that byte produces.
   h264aus_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .queue_has_room    (queue_has_room),
      .push              (push)
   );

   // The back end queues results and delivers them in order to the receiver.
   h264aus_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (queue_has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_frame_length    = head.frame_length;
   assign rsp_length_overflow = head.length_overflow;
   assign rsp_closes_stream   = head.closes_stream;

endmodule

// ===== sim/h264aus_frame_checker.sv =====
`timescale 1ns / 100ps

module h264aus_frame_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_wr_en,
   input  logic [h264aus_pkg::SCL_BITS-1:0]          csr_wr_data,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  logic [7:0]                                req_data_byte,
   input  logic                                      req_end_of_stream,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  logic [h264aus_pkg::FRAME_LENGTH_BITS-1:0] rsp_frame_length,
   input  logic                                      rsp_length_overflow,
   input  logic                                      rsp_closes_stream,
   output int unsigned                               frames_pending,
   output int unsigned                               mismatch_count
);
   import h264aus_pkg::*;

   logic [SCL_BITS-1:0]    code_length;
   logic [31:0]            recent_bytes;
   logic [2:0]             recent_count;
   logic [LENGTH_BITS-1:0] frame_bytes;
   logic                   skipping_sets;
   logic                   frame_saturated;
   result_type             expected_frames[$];

   // True when the bytes held end in a complete start code of the programmed length.
   function automatic logic start_code_behind();
      if (code_length == SCL_LONG) begin
         return recent_count >= 3'd4 && recent_bytes == 32'h0000_0001;
      end
      if (code_length == SCL_SHORT) begin
         return recent_count >= 3'd3 && recent_bytes[23:0] == 24'h00_0001;
      end
      return 1'b0;
   endfunction

   task automatic clear_stream();
      recent_bytes    = '0;
      recent_count    = '0;
      frame_bytes     = '0;
      skipping_sets   = 1'b1;
      frame_saturated = 1'b0;
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t ns: frame check: %s", $time, what);
      end
   endtask

   task automatic predict_frames(input logic [7:0] data_byte, input logic last_byte);
      logic       frame_ended;
      logic [4:0] nal_type;
      result_type frame;
      frame_ended = 1'b0;
      nal_type = data_byte[4:0];
      if (start_code_behind()) begin
         if (nal_type == NAL_TYPE_PPS) begin
            skipping_sets = 1'b1;
         end else if (nal_type != NAL_TYPE_SPS) begin
            if (!skipping_sets) begin
               frame.length_overflow = frame_saturated;
               frame.closes_stream   = 1'b0;
               if (frame_saturated) begin
                  frame.frame_length = LENGTH_LIMIT;
               end else if (frame_bytes >= code_length) begin
                  frame.frame_length = frame_bytes - code_length;
               end else begin
                  frame.frame_length = '0;
               end
               expected_frames.push_back(frame);
               frame_bytes     = LENGTH_BITS'(code_length) + LENGTH_BITS'(1);
               frame_saturated = 1'b0;
               frame_ended     = 1'b1;
            end else begin
               skipping_sets = 1'b0;
            end
         end
      end
      if (!frame_ended) begin
         if (frame_bytes >= LENGTH_LIMIT) begin
            frame_bytes     = LENGTH_LIMIT;
            frame_saturated = 1'b1;
         end else begin
            frame_bytes++;
         end
      end
      recent_bytes = {recent_bytes[23:0], data_byte};
      if (recent_count < 3'd4) begin
         recent_count++;
      end
      if (last_byte) begin
         frame.frame_length    = frame_saturated ? LENGTH_LIMIT : frame_bytes;
         frame.length_overflow = frame_saturated;
         frame.closes_stream   = 1'b1;
         expected_frames.push_back(frame);
         clear_stream();
      end
   endtask

   task automatic check_frame();
      result_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("unexpected frame length %0d overflow %0b closing %0b",
                                   rsp_frame_length, rsp_length_overflow, rsp_closes_stream));
      end else begin
         want = expected_frames.pop_front();
         if (rsp_frame_length !== want.frame_length ||
             rsp_length_overflow !== want.length_overflow ||
             rsp_closes_stream !== want.closes_stream) begin
            report_mismatch($sformatf("got length %0d overflow %0b closing %0b, expected %0d %0b %0b",
                                      rsp_frame_length, rsp_length_overflow, rsp_closes_stream,
                                      want.frame_length, want.length_overflow,
                                      want.closes_stream));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         code_length = SCL_LONG;
         clear_stream();
         expected_frames.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_frame();
         end
         if (csr_wr_en) begin
            code_length = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            predict_frames(req_data_byte, req_end_of_stream);
         end
      end
      frames_pending <= expected_frames.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import h264aus_pkg::*;

   // NAL unit types used to build well-formed streams, beside the two parameter
   // set types that the package already names.
   localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
   localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;

   // Start code length settings that match no start code at all.
   localparam logic [SCL_BITS-1:0] SCL_NONE_ZERO = 3'd0;
   localparam logic [SCL_BITS-1:0] SCL_NONE_MID  = 3'd5;
   localparam logic [SCL_BITS-1:0] SCL_NONE_MAX  = 3'd7;

   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_BYTES = 170;
   localparam int DRAIN_LIMIT   = 10000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [SCL_BITS-1:0]          csr_wr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_data_byte = '0;
   logic                         req_end_of_stream = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [FRAME_LENGTH_BITS-1:0] rsp_frame_length;
   logic                         rsp_length_overflow;
   logic                         rsp_closes_stream;

   int unsigned frames_pending;
   int unsigned mismatch_count;

   // Back-pressure settings of the current phase, in percent of cycles.
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   // The stimulus keeps its own note of the programmed length so that most
   // generated start codes are the ones the block is looking for.
   logic [SCL_BITS-1:0] code_length_now = SCL_LONG;
   int unsigned         bytes_sent;
   logic [7:0]          nal_bytes[$];

   // Directed streams: bit 8 marks the last byte of the stream.
   // With the four-byte code: an SPS while skip is still set, a PPS, an IDR that
   // clears skip, then a slice whose header byte is also the end of the stream,
   // so that a frame end and the closing remainder come from one transaction.
   logic [8:0] directed_long[20] = '{
      9'h000, 9'h000, 9'h000, 9'h001, 9'h067,
      9'h000, 9'h000, 9'h000, 9'h001, 9'h068,
      9'h000, 9'h000, 9'h000, 9'h001, 9'h065,
      9'h000, 9'h000, 9'h000, 9'h001, 9'h1e1
   };
   // With the three-byte code: a start code right after the stream restarts,
   // before the history holds three bytes, which must not match; then a real
   // one whose header is all ones and ends the stream.
   logic [8:0] directed_short[7] = '{
      9'h000, 9'h001, 9'h041,
      9'h000, 9'h000, 9'h001, 9'h1ff
   };

   // Each random segment runs with its own start code length; the set covers
   // both legal values, the extremes of the register and a value in between.
   logic [SCL_BITS-1:0] segment_code_length[SEGMENTS] = '{
      SCL_SHORT, SCL_LONG, SCL_NONE_MAX, SCL_SHORT,
      SCL_NONE_ZERO, SCL_LONG, SCL_NONE_MID, SCL_SHORT
   };

   always #5 clock = ~clock;

   h264_access_unit_splitter_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_length_overflow (rsp_length_overflow),
      .rsp_closes_stream   (rsp_closes_stream)
   );

   h264aus_frame_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_length    (rsp_frame_length),
      .rsp_length_overflow (rsp_length_overflow),
      .rsp_closes_stream   (rsp_closes_stream),
      .frames_pending      (frames_pending),
      .mismatch_count      (mismatch_count)
   );

   // The receiver decides its ready once per cycle. The stall rate is written
   // with a nonblocking assignment, so a phase change never races this block.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Offers one byte and returns at the edge that accepts the transaction.
   // Valid is left high afterwards; it is only lowered when the next call
   // decides to idle or when the stream pauses, so it is never lowered and
   // raised again within one time step.
   task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data_byte;
      req_end_of_stream <= last_byte;
      do begin
         @(posedge clock);
      end while (!req_ready);
      bytes_sent++;
   endtask

   // Stops sending and waits until every predicted frame has been received.
   // The pending count from the checker is registered and so trails, hence the
   // first edges waited; the trailing edges cover a byte that produced no frame
   // and is still in flight through the registered result queue.
   task automatic wait_for_frames();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && frames_pending != 0; n++) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_code_length(input logic [SCL_BITS-1:0] length_value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length_value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      code_length_now = length_value;
   endtask

   // One NAL unit: a start code, a header byte of a chosen type with random
   // upper bits, and a short payload. Now and then the start code has the other
   // length, the payload holds zero bytes, or the unit ends the stream.
   task automatic send_nal_unit();
      int         code_bytes;
      int         pick;
      int         payload_bytes;
      logic [7:0] header;
      logic       ends_stream;
      nal_bytes.delete();
      if (code_length_now == SCL_SHORT || code_length_now == SCL_LONG) begin
         code_bytes = code_length_now;
      end else begin
         code_bytes = $urandom_range(4, 3);
      end
      // Swap between the three- and four-byte forms once in a while.
      if ($urandom_range(9) == 0) begin
         code_bytes = 7 - code_bytes;
      end
      repeat (code_bytes - 1) nal_bytes.push_back(8'h00);
      nal_bytes.push_back(8'h01);
      header = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 15) begin
         header[4:0] = NAL_TYPE_SPS;
      end else if (pick < 30) begin
         header[4:0] = NAL_TYPE_PPS;
      end else if (pick < 55) begin
         header[4:0] = NAL_TYPE_IDR;
      end else if (pick < 85) begin
         header[4:0] = NAL_TYPE_SLICE;
      end
      nal_bytes.push_back(header);
      payload_bytes = ($urandom_range(4) == 0) ? 0 : $urandom_range(12, 1);
      repeat (payload_bytes) begin
         nal_bytes.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
      end
      ends_stream = ($urandom_range(7) == 0);
      foreach (nal_bytes[i]) begin
         send_byte(nal_bytes[i], ends_stream && i == nal_bytes.size() - 1);
      end
   endtask

   // A few bytes of any value, which may also end the stream.
   task automatic send_noise();
      int noise_bytes;
      noise_bytes = $urandom_range(6, 1);
      repeat (noise_bytes) send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the reset value of the start code length.
      foreach (directed_long[i]) begin
         send_byte(directed_long[i][7:0], directed_long[i][8]);
      end
      wait_for_frames();
      write_code_length(SCL_SHORT);
      foreach (directed_short[i]) begin
         send_byte(directed_short[i][7:0], directed_short[i][8]);
      end

      // Random part. Every segment begins with the sender paused until all
      // expected frames have arrived, so the register is written while the
      // block is idle; the write often lands in the middle of a stream, which
      // exercises a length change within a frame. The four idling phases
      // repeat twice: none, sender idle, receiver stalling, and both.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_frames();
         write_code_length(segment_code_length[seg]);
         case (seg % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 0;
            end
            1: begin
               sender_idle_pct = 46;
               receiver_stall_pct <= 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct <= 46;
            end
            default: begin
               sender_idle_pct = 23;
               receiver_stall_pct <= 23;
            end
         endcase
         bytes_sent = 0;
         // Mostly well-formed NAL units; the rest is noise that breaks them up.
         while (bytes_sent < SEGMENT_BYTES) begin
            if ($urandom_range(99) < 75) begin
               send_nal_unit();
            end else begin
               send_noise();
            end
         end
      end

      wait_for_frames();
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
